// File: rtl/adq_pkg.sv
// Package for the array deque: transfer types, command and status codes, control enums.
`timescale 1ns / 1ps
package adq_pkg;

  localparam int CMD_W   = 3;
  localparam int DATA_W  = 32;
  localparam int STAT_W  = 2;
  localparam int POS_W   = 4;
  localparam int FILL_W  = 5;

  localparam logic [CMD_W-1:0] CMD_INS_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INS_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REM_FRONT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REM_BACK  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SHOW      = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]         command;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] element;
    logic [POS_W-1:0]         position;
    logic [FILL_W-1:0]        fill_count;
    logic                     last;
  } out_item_t;

  // Source select for one storage cell.
  typedef enum logic [2:0] {
    SEL_HOLD,
    SEL_LEFT,
    SEL_RIGHT,
    SEL_HEAD,
    SEL_LOAD
  } cell_sel_t;

  // Whole-chain operation for one cycle.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_PUSH_FRONT,
    OP_PUSH_BACK,
    OP_POP_FRONT,
    OP_ROTATE
  } chain_op_t;

  typedef enum logic {
    S_IDLE,
    S_SHOW
  } state_t;

endpackage

// File: rtl/adq_cell.sv
// One storage cell of the deque chain: a data register fed from itself, a neighbor, cell 0 or the load input.
`timescale 1ns / 1ps
module adq_cell (
  input  logic                             clk,
  input  adq_pkg::cell_sel_t               sel,
  input  logic signed [adq_pkg::DATA_W-1:0] left_d,
  input  logic signed [adq_pkg::DATA_W-1:0] right_d,
  input  logic signed [adq_pkg::DATA_W-1:0] head_d,
  input  logic signed [adq_pkg::DATA_W-1:0] load_d,
  output logic signed [adq_pkg::DATA_W-1:0] q
);
  import adq_pkg::*;

  logic signed [DATA_W-1:0] data_r;
  logic signed [DATA_W-1:0] data_nxt;

  always_comb begin
    case (sel)
      SEL_HOLD:  data_nxt = data_r;
      SEL_LEFT:  data_nxt = left_d;
      SEL_RIGHT: data_nxt = right_d;
      SEL_HEAD:  data_nxt = head_d;
      SEL_LOAD:  data_nxt = load_d;
      default:   data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q = data_r;

endmodule

// File: rtl/array_deque_unit.sv
// Bounded deque of signed 32-bit elements held in a chain of shift cells.
//
// Input channel in_valid/in_stall/in_data carries a command and a value; the
// result channel out_valid/out_stall/out_data returns status, element,
// position, fill count and a last flag. A transfer happens on a rising edge
// with valid high and stall low.
// Inserts and removes give one result, registered in the cycle after the input
// transfer; a new command is taken every cycle while the output keeps moving.
// Show of N elements gives N results, one per cycle while the output is not
// stalled: the chain rotates one slot per result and cell 0 is emitted, so after
// N steps the order is back as it was. Input is stalled while the show runs.
// Shifts of the whole list move all of its cells together; cells beyond it hold.
// A stalled result holds in the output register; input stalls behind it.
// Reset (rst_n low, synchronous) empties the list and drops any pending
// result; cell contents are not cleared and are read only once written.
`timescale 1ns / 1ps
module array_deque_unit #(
  parameter int DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  adq_pkg::in_item_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output adq_pkg::out_item_t out_data
);
  import adq_pkg::*;

  localparam int OCC_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);

  state_t              state_r, state_nxt;
  logic [OCC_W-1:0]    occ_r, occ_nxt;
  logic [IDX_W-1:0]    cnt_r, cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_data_r, out_data_nxt;
  chain_op_t           op;
  logic                out_ready;
  logic                accept;
  logic                is_full;
  logic                is_empty;
  logic                show_last;

  logic signed [DATA_W-1:0] cell_q [DEPTH];
  cell_sel_t                cell_sel [DEPTH];

  assign out_ready = !out_valid_r || !out_stall;
  assign in_stall  = (state_r == S_SHOW) || !out_ready;
  assign accept    = in_valid && !in_stall;
  assign is_full   = (occ_r == OCC_W'(DEPTH));
  assign is_empty  = (occ_r == '0);
  assign show_last = ((OCC_W'(cnt_r) + OCC_W'(1)) == occ_r);

  always_comb begin
    state_nxt     = state_r;
    occ_nxt       = occ_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    op            = OP_NONE;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.status     = ST_OK;
          out_data_nxt.element    = '0;
          out_data_nxt.position   = '0;
          out_data_nxt.last       = 1'b1;
          case (in_data.command)
            CMD_INS_FRONT, CMD_INS_BACK: begin
              if (is_full) begin
                out_data_nxt.status = ST_FULL;
              end else begin
                op      = (in_data.command == CMD_INS_FRONT) ? OP_PUSH_FRONT : OP_PUSH_BACK;
                occ_nxt = occ_r + OCC_W'(1);
              end
            end
            CMD_REM_FRONT, CMD_REM_BACK: begin
              if (is_empty) begin
                out_data_nxt.status = ST_EMPTY;
              end else begin
                if (in_data.command == CMD_REM_FRONT) op = OP_POP_FRONT;
                occ_nxt = occ_r - OCC_W'(1);
              end
            end
            CMD_SHOW: begin
              if (is_empty) begin
                out_data_nxt.status = ST_EMPTY;
              end else begin
                out_valid_nxt = 1'b0;
                state_nxt     = S_SHOW;
                cnt_nxt       = '0;
              end
            end
            default: ;
          endcase
          out_data_nxt.fill_count = FILL_W'(occ_nxt);
        end
      end
      S_SHOW: begin
        if (out_ready) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.status     = ST_OK;
          out_data_nxt.element    = cell_q[0];
          out_data_nxt.position   = POS_W'(cnt_r);
          out_data_nxt.fill_count = FILL_W'(occ_r);
          out_data_nxt.last       = show_last;
          op                      = OP_ROTATE;
          cnt_nxt                 = cnt_r + IDX_W'(1);
          if (show_last) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Per-cell source select; cell i compares its own index against occupancy.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic below_occ;    // i < occ
    logic below_last;   // i + 1 < occ
    logic at_last;      // i + 1 == occ
    logic signed [DATA_W-1:0] left_d;
    logic signed [DATA_W-1:0] right_d;

    assign below_occ  = (OCC_W'(i) < occ_r);
    assign below_last = (OCC_W'(i + 1) < occ_r);
    assign at_last    = (OCC_W'(i + 1) == occ_r);

    if (i == 0) begin : g_first
      assign left_d = in_data.value;
    end else begin : g_mid
      assign left_d = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right_d = cell_q[i];
    end else begin : g_body
      assign right_d = cell_q[i+1];
    end

    always_comb begin
      case (op)
        OP_PUSH_FRONT: cell_sel[i] = (below_occ || OCC_W'(i) == occ_r) ? SEL_LEFT : SEL_HOLD;
        OP_PUSH_BACK:  cell_sel[i] = (OCC_W'(i) == occ_r) ? SEL_LOAD : SEL_HOLD;
        OP_POP_FRONT:  cell_sel[i] = below_last ? SEL_RIGHT : SEL_HOLD;
        OP_ROTATE:     cell_sel[i] = below_last ? SEL_RIGHT : (at_last ? SEL_HEAD : SEL_HOLD);
        default:       cell_sel[i] = SEL_HOLD;
      endcase
    end

    adq_cell u_cell (
      .clk     (clk),
      .sel     (cell_sel[i]),
      .left_d  (left_d),
      .right_d (right_d),
      .head_d  (cell_q[0]),
      .load_d  (in_data.value),
      .q       (cell_q[i])
    );
  end

endmodule

// File: rtl/adq_checker.sv
// Port-level checks for the array deque, bound to the top level.
`timescale 1ns / 1ps
module adq_checker #(
  parameter int DEPTH = 16
) (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input adq_pkg::out_item_t out_data
);
  import adq_pkg::*;

  // A stalled result is held.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Error statuses end the item.
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> out_data.last)
    else $error("error status without last");

  // Empty status only with an empty list.
  a_empty_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_EMPTY |-> out_data.fill_count == '0)
    else $error("empty status with nonzero fill");

  // Show results follow back to back with rising position.
  a_show_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.last |=>
      out_valid && out_data.position == POS_W'($past(out_data.position) + 1'b1))
    else $error("show sequence broken");

  // Fill never exceeds capacity.
  a_fill_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_data.fill_count) <= 32'(DEPTH))
    else $error("fill count above depth");

endmodule

bind array_deque_unit adq_checker #(.DEPTH(DEPTH)) u_adq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
